// ----- rtl/core/hsv_pkg.sv -----
// ============================================================================
// hsv_pkg
// Shared widths, sector codes and stage-advance struct for the HSV to RGB
// converter.
// ============================================================================
`default_nettype none

package hsv_pkg;

    // Output code width before the 16-bit port cut, and fraction bits of f
    localparam int OUT_BITS  = 16;
    localparam int FRAC_BITS = 16;

    // Fixed field formats
    localparam int HUE_W   = 16;          // Q0.16 hue
    localparam int LVL_W   = 17;          // Q1.16 saturation / brightness
    localparam int ONE_EXP = 16;          // 1.0 = 2^16 in Q1.16
    localparam int CH_W    = 16;          // output port width
    localparam int SEC_W   = 3;           // sector 0..5

    // Derived datapath widths
    localparam int F_W   = FRAC_BITS;
    localparam int SF_W  = LVL_W + F_W;            // s * f, unsigned
    localparam int FAC_W = LVL_W + F_W + 1;        // signed factors p/q/t
    localparam int X_W   = LVL_W + 1 + FAC_W;      // signed v * factor
    localparam int HI_W  = X_W + OUT_BITS - 32;    // x*full >> 32
    localparam int R_W   = HI_W + 1;               // rounding sum

    // Hue sectors
    localparam logic [SEC_W-1:0] SEC_RED_YEL = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YEL_GRN = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GRN_CYN = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYN_BLU = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLU_MAG = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAG_RED = 3'd5;

    // Load enables for the two rounding stages
    typedef struct packed {
        logic load_hi;
        logic load_code;
    } hsv_adv_t;

endpackage

`default_nettype wire

// ----- rtl/core/hsv_chan_round.sv -----
// ============================================================================
// hsv_chan_round
// Two-stage scale, round-half-up and clamp of one channel value to a code.
// ============================================================================
`default_nettype none

module hsv_chan_round (
    input  wire logic                                  clk,
    input  wire hsv_pkg::hsv_adv_t                     adv,
    input  wire logic signed [hsv_pkg::X_W-1:0]        x,
    output logic             [hsv_pkg::OUT_BITS-1:0]   code
);

    localparam int MW = hsv_pkg::X_W + hsv_pkg::OUT_BITS;

    localparam logic [hsv_pkg::R_W-1:0] FullCode =
        hsv_pkg::R_W'({hsv_pkg::OUT_BITS{1'b1}});
    localparam logic [hsv_pkg::R_W-1:0] HalfLsb =
        hsv_pkg::R_W'(1) << (hsv_pkg::F_W - 1);

    logic                              pos;
    logic [hsv_pkg::X_W-1:0]           ux;
    logic [MW-1:0]                     scaled;
    logic [hsv_pkg::HI_W-1:0]          hi_next;
    logic [hsv_pkg::HI_W-1:0]          hi_reg;
    logic [hsv_pkg::R_W-1:0]           sum;
    logic [hsv_pkg::R_W-1:0]           rnd;
    logic [hsv_pkg::OUT_BITS-1:0]      code_next;
    logic [hsv_pkg::OUT_BITS-1:0]      code_reg;

    // x * (2^OUT_BITS - 1) as shift minus x; nonpositive values give zero
    always_comb
    begin
        pos     = !x[hsv_pkg::X_W-1] && (x != '0);
        ux      = x;
        scaled  = {ux, {hsv_pkg::OUT_BITS{1'b0}}} - MW'(ux);
        hi_next = pos ? scaled[MW-1:32] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_hi)
        begin
            hi_reg <= hi_next;
        end
    end

    // round half up at FRAC_BITS, then clamp to full scale
    always_comb
    begin
        sum = {1'b0, hi_reg} + HalfLsb;
        rnd = sum >> hsv_pkg::F_W;
        if (rnd > FullCode)
        begin
            code_next = {hsv_pkg::OUT_BITS{1'b1}};
        end
        else
        begin
            code_next = rnd[hsv_pkg::OUT_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.load_code)
        begin
            code_reg <= code_next;
        end
    end

    assign code = code_reg;

endmodule

`default_nettype wire

// ----- rtl/core/hsv_to_rgb_convert.sv -----
// ============================================================================
// hsv_to_rgb_convert
// Pixel-rate HSV to RGB converter, five register stages, valid/ready channels.
// ============================================================================
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------
//   in      | sink      | in_valid / in_ready  | hue_turn, sat_level, bright_level
//   out     | source    | out_valid / out_ready| red_out, green_out, blue_out
//
// One pixel per clock sustained while out_ready stays high. An input transfer
// loads stage 1; the pixel then moves through stages 2, 3, 4 and 5, and
// out_valid is the stage 5 valid bit. Each stage loads when it is empty
// or its successor loads, so bubbles close up and the block keeps taking
// pixels while a result waits at the output, until all five stages are full.
// Reset (rst_n low) clears all stage valid bits; payload registers are not
// reset. A stall holds every occupied stage; nothing is dropped or repeated.
//
// Stages:
//   1  hue*6 -> sector, fraction f
//   2  s*f   -> factors for p, q, t
//   3  v * factor (three multipliers), v scaled
//   4  sector select, scale by full-scale code
//   5  round half up, clamp -> output register
// ============================================================================
`default_nettype none

module hsv_to_rgb_convert (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [hsv_pkg::HUE_W-1:0]     hue_turn,
    input  wire logic [hsv_pkg::LVL_W-1:0]     sat_level,
    input  wire logic [hsv_pkg::LVL_W-1:0]     bright_level,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [hsv_pkg::CH_W-1:0]      red_out,
    output logic      [hsv_pkg::CH_W-1:0]      green_out,
    output logic      [hsv_pkg::CH_W-1:0]      blue_out
);

    localparam int H6_W = hsv_pkg::HUE_W + hsv_pkg::SEC_W;
    localparam int FX_W = hsv_pkg::HUE_W + hsv_pkg::F_W;

    // 1.0 in Q(16+FRAC_BITS), the product of the two unit scales
    localparam logic signed [hsv_pkg::FAC_W-1:0] UnitQ =
        hsv_pkg::FAC_W'(1) <<< (hsv_pkg::ONE_EXP + hsv_pkg::F_W);
    localparam logic signed [hsv_pkg::FAC_W-1:0] OneLvl =
        hsv_pkg::FAC_W'(1) <<< hsv_pkg::ONE_EXP;

    // ------------------------------------------------------------------
    // Stage valid bits and the ready chain
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !v5_reg || out_ready;
    assign rdy4 = !v4_reg || rdy5;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;

    assign in_ready  = rdy1;
    assign out_valid = v5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: sector and fraction
    // ------------------------------------------------------------------
    logic [H6_W-1:0]              h6;
    logic [FX_W-1:0]              f_wide;
    logic [hsv_pkg::SEC_W-1:0]    sec1_reg;
    logic [hsv_pkg::F_W-1:0]      f1_reg;
    logic [hsv_pkg::LVL_W-1:0]    s1_reg;
    logic [hsv_pkg::LVL_W-1:0]    vl1_reg;

    always_comb
    begin
        h6     = H6_W'({hue_turn, 2'b00}) + H6_W'({hue_turn, 1'b0});
        // f truncated to FRAC_BITS fraction bits
        f_wide = {h6[hsv_pkg::HUE_W-1:0], {hsv_pkg::F_W{1'b0}}} >> hsv_pkg::HUE_W;
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            sec1_reg <= h6[H6_W-1:hsv_pkg::HUE_W];
            f1_reg   <= f_wide[hsv_pkg::F_W-1:0];
            s1_reg   <= sat_level;
            vl1_reg  <= bright_level;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: p = 1-s, q = 1-s*f, t = 1-s+s*f (all scaled by UnitQ)
    // ------------------------------------------------------------------
    logic        [hsv_pkg::SF_W-1:0]   sf;
    logic signed [hsv_pkg::FAC_W-1:0]  sf_ext;
    logic signed [hsv_pkg::FAC_W-1:0]  s_ext;
    logic signed [hsv_pkg::FAC_W-1:0]  pfac;
    logic signed [hsv_pkg::FAC_W-1:0]  pf2_reg, qf2_reg, tf2_reg;
    logic [hsv_pkg::SEC_W-1:0]         sec2_reg;
    logic [hsv_pkg::LVL_W-1:0]         vl2_reg;

    always_comb
    begin
        sf     = hsv_pkg::SF_W'(s1_reg) * hsv_pkg::SF_W'(f1_reg);
        sf_ext = hsv_pkg::FAC_W'(sf);
        s_ext  = hsv_pkg::FAC_W'(s1_reg);
        pfac   = (OneLvl - s_ext) <<< hsv_pkg::F_W;
    end

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            pf2_reg  <= pfac;
            qf2_reg  <= UnitQ - sf_ext;
            tf2_reg  <= pfac + sf_ext;
            sec2_reg <= sec1_reg;
            vl2_reg  <= vl1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: multiply by brightness
    // ------------------------------------------------------------------
    logic signed [hsv_pkg::LVL_W:0]    v_sgn;
    logic signed [hsv_pkg::X_W-1:0]    pq3_reg, qq3_reg, tq3_reg, vq3_reg;
    logic [hsv_pkg::SEC_W-1:0]         sec3_reg;

    assign v_sgn = {1'b0, vl2_reg};

    always_ff @(posedge clk)
    begin
        if (rdy3 && v2_reg)
        begin
            pq3_reg  <= hsv_pkg::X_W'(v_sgn) * hsv_pkg::X_W'(pf2_reg);
            qq3_reg  <= hsv_pkg::X_W'(v_sgn) * hsv_pkg::X_W'(qf2_reg);
            tq3_reg  <= hsv_pkg::X_W'(v_sgn) * hsv_pkg::X_W'(tf2_reg);
            vq3_reg  <= hsv_pkg::X_W'(vl2_reg) << (hsv_pkg::ONE_EXP + hsv_pkg::F_W);
            sec3_reg <= sec2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4/5: sector routing, then per-channel scale and round
    // ------------------------------------------------------------------
    logic signed [hsv_pkg::X_W-1:0]    r_x, g_x, b_x;
    logic [hsv_pkg::OUT_BITS-1:0]      r_code, g_code, b_code;
    hsv_pkg::hsv_adv_t                 adv;

    always_comb
    begin
        case (sec3_reg)
            hsv_pkg::SEC_YEL_GRN:
            begin
                r_x = qq3_reg; g_x = vq3_reg; b_x = pq3_reg;
            end
            hsv_pkg::SEC_GRN_CYN:
            begin
                r_x = pq3_reg; g_x = vq3_reg; b_x = tq3_reg;
            end
            hsv_pkg::SEC_CYN_BLU:
            begin
                r_x = pq3_reg; g_x = qq3_reg; b_x = vq3_reg;
            end
            hsv_pkg::SEC_BLU_MAG:
            begin
                r_x = tq3_reg; g_x = pq3_reg; b_x = vq3_reg;
            end
            hsv_pkg::SEC_MAG_RED:
            begin
                r_x = vq3_reg; g_x = pq3_reg; b_x = qq3_reg;
            end
            default:
            begin
                // red to yellow
                r_x = vq3_reg; g_x = tq3_reg; b_x = pq3_reg;
            end
        endcase
    end

    always_comb
    begin
        adv.load_hi   = rdy4 && v3_reg;
        adv.load_code = rdy5 && v4_reg;
    end

    hsv_chan_round u_red (
        .clk  (clk),
        .adv  (adv),
        .x    (r_x),
        .code (r_code)
    );

    hsv_chan_round u_green (
        .clk  (clk),
        .adv  (adv),
        .x    (g_x),
        .code (g_code)
    );

    hsv_chan_round u_blue (
        .clk  (clk),
        .adv  (adv),
        .x    (b_x),
        .code (b_code)
    );

    assign red_out   = hsv_pkg::CH_W'(r_code);
    assign green_out = hsv_pkg::CH_W'(g_code);
    assign blue_out  = hsv_pkg::CH_W'(b_code);

`ifndef SYNTHESIS
    // an input transfer always lands in stage 1
    a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> v1_reg)
        else $error("input transfer not captured in stage 1");

    // occupancy grows by at most one pixel per cycle
    a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg}) <=
                  $past($countones({v1_reg, v2_reg, v3_reg, v4_reg, v5_reg})) + 1))
        else $error("pipeline occupancy jumped");

    // a blocked stage 3 keeps its products
    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !rdy3) |=> ($stable(pq3_reg) && $stable(qq3_reg) &&
                               $stable(tq3_reg) && $stable(sec3_reg)))
        else $error("stalled stage 3 changed");
`endif

endmodule

`default_nettype wire

// ----- sim/hsv_to_rgb_check.sv -----
// ============================================================================
// hsv_to_rgb_check
// Watches both channels of the HSV to RGB converter, predicts each output
// pixel from the input transfer and compares it with what the block returns.
// ============================================================================

module hsv_to_rgb_check (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_ready,
    input  wire logic [hsv_pkg::HUE_W-1:0]    hue_turn,
    input  wire logic [hsv_pkg::LVL_W-1:0]    sat_level,
    input  wire logic [hsv_pkg::LVL_W-1:0]    bright_level,
    input  wire logic                         out_valid,
    input  wire logic                         out_ready,
    input  wire logic [hsv_pkg::CH_W-1:0]     red_out,
    input  wire logic [hsv_pkg::CH_W-1:0]     green_out,
    input  wire logic [hsv_pkg::CH_W-1:0]     blue_out,
    output int                                fail_count,
    output int                                pending,
    output int                                checked
);

    typedef struct packed {
        logic [hsv_pkg::HUE_W-1:0] hue;
        logic [hsv_pkg::LVL_W-1:0] sat;
        logic [hsv_pkg::LVL_W-1:0] bright;
        logic [hsv_pkg::CH_W-1:0]  red;
        logic [hsv_pkg::CH_W-1:0]  green;
        logic [hsv_pkg::CH_W-1:0]  blue;
    } pixel_due_t;

    pixel_due_t rgb_due[$];
    int         fails;
    int         seen;

    initial
    begin
        fails = 0;
        seen  = 0;
    end

    // Q(32+FRAC_BITS) value -> rounded (half up), clamped code; nonpositive gives zero
    function automatic logic [hsv_pkg::CH_W-1:0] round_clamp(longint x);
        longint unsigned full, ux, xh, xl, lo, hi, r;
        full = (64'd1 << hsv_pkg::OUT_BITS) - 64'd1;
        if (x <= 0)
            return '0;
        ux = x;
        xh = ux >> 32;
        xl = ux & 64'hFFFF_FFFF;
        lo = xl * full;
        hi = xh * full + (lo >> 32) + (64'd1 << (hsv_pkg::FRAC_BITS - 1));
        r  = hi >> hsv_pkg::FRAC_BITS;
        if (r > full)
            r = full;
        return r[hsv_pkg::CH_W-1:0];
    endfunction

    function automatic pixel_due_t hsv_expected(logic [hsv_pkg::HUE_W-1:0] hue,
                                                logic [hsv_pkg::LVL_W-1:0] sat,
                                                logic [hsv_pkg::LVL_W-1:0] bright);
        pixel_due_t                px;
        longint unsigned           h6, frac16;
        logic [hsv_pkg::SEC_W-1:0] sector;
        longint                    onef, unit, f, sl, vl, vq, pq, qq, tq, rr, gg, bb;
        h6     = longint'(hue) * 6;
        sector = hsv_pkg::SEC_W'(h6 >> 16);
        frac16 = h6 & 64'hFFFF;
        onef   = longint'(1) << hsv_pkg::FRAC_BITS;
        unit   = 65536 * onef;
        f      = longint'((frac16 << hsv_pkg::FRAC_BITS) >> 16);
        sl     = longint'(sat);
        vl     = longint'(bright);
        vq     = vl * unit;
        pq     = vl * ((65536 - sl) * onef);
        qq     = vl * (unit - sl * f);
        tq     = vl * (unit - sl * (onef - f));
        case (sector)
            hsv_pkg::SEC_YEL_GRN: begin rr = qq; gg = vq; bb = pq; end
            hsv_pkg::SEC_GRN_CYN: begin rr = pq; gg = vq; bb = tq; end
            hsv_pkg::SEC_CYN_BLU: begin rr = pq; gg = qq; bb = vq; end
            hsv_pkg::SEC_BLU_MAG: begin rr = tq; gg = pq; bb = vq; end
            hsv_pkg::SEC_MAG_RED: begin rr = vq; gg = pq; bb = qq; end
            default:              begin rr = vq; gg = tq; bb = pq; end
        endcase
        px.hue    = hue;
        px.sat    = sat;
        px.bright = bright;
        px.red    = round_clamp(rr);
        px.green  = round_clamp(gg);
        px.blue   = round_clamp(bb);
        return px;
    endfunction

    always @(posedge clk)
    begin
        pixel_due_t px;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                rgb_due.push_back(hsv_expected(hue_turn, sat_level, bright_level));
            if (out_valid && out_ready)
            begin
                seen++;
                if (rgb_due.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected pixel: rgb %0d %0d %0d",
                                 red_out, green_out, blue_out);
                    fails++;
                end
                else
                begin
                    px = rgb_due.pop_front();
                    if (px.red !== red_out || px.green !== green_out ||
                        px.blue !== blue_out)
                    begin
                        if (fails < 10)
                            $display({"pixel h=%0d s=%0d v=%0d: ",
                                      "expected %0d %0d %0d, got %0d %0d %0d"},
                                     px.hue, px.sat, px.bright,
                                     px.red, px.green, px.blue,
                                     red_out, green_out, blue_out);
                        fails++;
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= rgb_due.size();
        checked    <= seen;
    end

endmodule

// ----- sim/tb_hsv_to_rgb_convert.sv -----
// ============================================================================
// tb_hsv_to_rgb_convert
// Stimulus and verdict for the HSV to RGB converter: directed corner pixels,
// then random pixels under random and held-off backpressure on both sides.
// ============================================================================

module tb_hsv_to_rgb_convert;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 120;   // long receiver hold-off
    localparam int IDLE_PCT    = 36;    // idle cycles per hundred, each side

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      in_valid     = 1'b0;
    logic [hsv_pkg::HUE_W-1:0] hue_turn     = '0;
    logic [hsv_pkg::LVL_W-1:0] sat_level    = '0;
    logic [hsv_pkg::LVL_W-1:0] bright_level = '0;
    logic                      out_ready    = 1'b0;
    logic                      in_ready;
    logic                      out_valid;
    logic [hsv_pkg::CH_W-1:0]  red_out;
    logic [hsv_pkg::CH_W-1:0]  green_out;
    logic [hsv_pkg::CH_W-1:0]  blue_out;

    int fail_count;
    int pending;
    int checked;
    int pixels_sent = 0;
    int cycles      = 0;

    // Shared between the sender and receiver processes
    bit steady   = 1'b0;   // no idling on either side
    bit hold_req = 1'b0;   // receiver to hold off; cleared by the receiver

    always #2 clk = ~clk;

    hsv_to_rgb_convert u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hue_turn     (hue_turn),
        .sat_level    (sat_level),
        .bright_level (bright_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out)
    );

    hsv_to_rgb_check u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hue_turn     (hue_turn),
        .sat_level    (sat_level),
        .bright_level (bright_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // Watchdog: a hung handshake ends the run as a failure
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixels still due", cycles, pending);
            $display("hsv_to_rgb_convert: mismatch");
            $finish;
        end
    end

    // Receiver: random readiness, a steady stretch, and one long hold-off.
    // The hold-off is counted here so the sender keeps offering pixels and
    // the pipeline fills and drops in_ready.
    initial
    begin
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (steady)
                    out_ready <= 1'b1;
                else
                    out_ready <= ($urandom_range(99) >= IDLE_PCT);
                @(posedge clk);
            end
        end
    end

    // One pixel transfer. Idle cycles go in front; valid is held with a
    // stable payload until the block takes it.
    task automatic send_pixel(logic [hsv_pkg::HUE_W-1:0] hue,
                              logic [hsv_pkg::LVL_W-1:0] sat,
                              logic [hsv_pkg::LVL_W-1:0] bright);
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        in_valid     <= 1'b1;
        hue_turn     <= hue;
        sat_level    <= sat;
        bright_level <= bright;
        do
            @(posedge clk);
        while (!in_ready);
        pixels_sent++;
    endtask

    // Level mix: mostly in range, some zero and unity, some with all 17 bits
    // random, which can go over 1.0
    function automatic logic [hsv_pkg::LVL_W-1:0] pick_level();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        else if (pick < 15)
            return hsv_pkg::LVL_W'(1 << hsv_pkg::ONE_EXP);
        else if (pick < 25)
            return hsv_pkg::LVL_W'($urandom_range((1 << hsv_pkg::LVL_W) - 1));
        return hsv_pkg::LVL_W'($urandom_range(1 << hsv_pkg::ONE_EXP));
    endfunction

    function automatic logic [hsv_pkg::HUE_W-1:0] pick_hue();
        int pick;
        pick = $urandom_range(99);
        // near a sector edge now and then: k/6 of a turn, +-2
        if (pick < 15)
            return hsv_pkg::HUE_W'(($urandom_range(5) * 65536) / 6 +
                                   $urandom_range(4) - 2);
        return hsv_pkg::HUE_W'($urandom_range((1 << hsv_pkg::HUE_W) - 1));
    endfunction

    task automatic send_random(int count);
        repeat (count)
            send_pixel(pick_hue(), pick_level(), pick_level());
    endtask

    // Sender stops until every predicted pixel has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, grey, sector edges, wrap, over-range
        send_pixel(16'd0,     17'd0,      17'd0);
        send_pixel(16'd0,     17'd0,      17'd65536);     // grey, full scale
        send_pixel(16'd0,     17'd0,      17'd1);         // grey, smallest step
        send_pixel(16'd30000, 17'd0,      17'd131071);    // grey, over-bright clamp
        send_pixel(16'd65535, 17'd65536,  17'd65536);     // hue just below wrap
        send_pixel(16'd10922, 17'd65536,  17'd65536);     // top of red-yellow
        send_pixel(16'd10923, 17'd65536,  17'd65536);     // start of yellow-green
        send_pixel(16'd21845, 17'd65536,  17'd65536);
        send_pixel(16'd21846, 17'd65536,  17'd65536);
        send_pixel(16'd32767, 17'd65536,  17'd65536);
        send_pixel(16'd32768, 17'd32768,  17'd32768);
        send_pixel(16'd43690, 17'd65536,  17'd65536);
        send_pixel(16'd43691, 17'd65536,  17'd65536);
        send_pixel(16'd54613, 17'd65536,  17'd65536);
        send_pixel(16'd54614, 17'd65536,  17'd65536);
        send_pixel(16'd12345, 17'd131071, 17'd65536);     // over-saturated
        send_pixel(16'd50000, 17'd100000, 17'd40000);     // over-saturated, negative p
        send_pixel(16'd20000, 17'd65536,  17'd131071);    // over-bright
        send_pixel(16'd65535, 17'd131071, 17'd131071);    // every input bit high
        send_pixel(16'd1,     17'd65535,  17'd65535);
        send_pixel(16'd5461,  17'd20000,  17'd40000);
        send_pixel(16'd40000, 17'd1,      17'd1);
        send_pixel(16'd60000, 17'd65536,  17'd0);         // black
        wait_drained();

        send_random(200);

        // Steady stretch: full rate on both sides
        steady = 1'b1;
        send_random(150);
        steady = 1'b0;

        // Receiver holds off while the sender keeps offering pixels
        hold_req = 1'b1;
        steady   = 1'b1;
        send_random(60);
        steady   = 1'b0;
        wait_drained();

        send_random(270);

        // Drain, then a few quiet cycles to catch any stray output
        wait_drained();
        repeat (20) @(posedge clk);

        $display("%0d pixels sent, %0d results checked, %0d cycles", pixels_sent, checked,
                 cycles);
        $display("covered grey, all hue sectors and edges, over-range levels, stalls and hold-off");
        if (fail_count == 0 && pending == 0)
            $display("hsv_to_rgb_convert: match");
        else
            $display("hsv_to_rgb_convert: mismatch");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/hsv_pkg.sv
rtl/core/hsv_chan_round.sv
rtl/core/hsv_to_rgb_convert.sv
sim/hsv_to_rgb_check.sv
sim/tb_hsv_to_rgb_convert.sv
